// ===== hw/rtl/sqm_pkg.sv =====
`timescale 1ns / 1ps

package sqm_pkg;

	// Configuration register indexes
	localparam logic REG_OPERATION = 1'b0;
	localparam logic REG_DIMENSION = 1'b1;

	// Operation codes; code three falls back to add
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;

	localparam int IDX_W  = 3;
	localparam int DIM_W  = 4;
	localparam int CNT_W  = 7;
	localparam int DATA_W = 32;

	// Control tag that travels with each read through the pipeline
	typedef struct packed {
		logic             first;  // first term of a result element
		logic             lastk;  // final term of a result element
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             lastel; // final element of the matrix
	} tag_t;

endpackage

// ===== hw/rtl/sqm_ram.sv =====
`timescale 1ns / 1ps

module sqm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		// hold the read register while disabled
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/square_matrix_add_sub_mul_unit.sv =====
`timescale 1ns / 1ps

// Square matrix add / subtract / multiply.
// Write operation (index 0) and dimension n (index 1) through wr_en, wr_index
// and wr_data while the block is idle. Writing the dimension restarts loading.
// The slave stream takes one item per cycle: an element of A and the element
// of B at the same place, in row-major order. The n*n-th item starts a run;
// s_tready stays low for the run and comes back once every read is issued.
// The master stream gives the n*n result elements in row-major order with
// row and column indices, tlast on the final one.
// One shared unit (a 32x32 multiplier, adder or subtractor, then an
// accumulator) handles one term per cycle while not stalled, behind a
// three-stage read pipeline: store read, term, accumulate into the output
// register. Add and subtract give one element a cycle; the product sums n
// terms per element, n*n*n terms per matrix. While a result waits with
// m_tready low, the whole pipeline holds in place.
// Reset clears the load count, selects add and sets n to MAX_DIM; the
// stores themselves are not cleared.

module square_matrix_add_sub_mul_unit #(
	parameter int MAX_DIM = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // a_elem[31:0], b_elem[63:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // value[31:0], row[34:32], col[37:35], zero pad
	output logic        m_tlast,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [3:0]  wr_data
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int IW    = sqm_pkg::IDX_W;
	localparam int DW    = sqm_pkg::DATA_W;

	typedef enum logic {
		ST_LOAD,
		ST_RUN
	} state_t;

	state_t state_q;

	logic [1:0]               op_q;
	logic [sqm_pkg::DIM_W-1:0] dim_q;
	logic [sqm_pkg::CNT_W-1:0] load_q;

	logic [IW-1:0] i_q, j_q, k_q;
	logic [AW-1:0] rowbase_q, kbase_q;

	logic [sqm_pkg::DIM_W-1:0] n_act;
	logic [sqm_pkg::DIM_W-1:0] n_m1;
	logic [sqm_pkg::CNT_W-1:0] total;
	logic                      is_mul, is_sub;
	logic                      k_end, j_end, i_end;
	logic                      accept, stall, issue;
	sqm_pkg::tag_t             tag0, tag_s1, tag_s2;
	logic                      v_s1, v_s2;
	logic [AW-1:0]             addr_a, addr_b, wr_addr;
	logic [DW-1:0]             a_rd, b_rd, prod_lo, term_d, term_s2, acc_q, sum;

	logic          out_valid_q;
	logic [DW-1:0] value_q;
	logic [IW-1:0] row_q, col_q;
	logic          last_q;

	// Active dimension: zero reads as one, above MAX_DIM saturates
	always_comb begin
		if (dim_q == '0) begin
			n_act = sqm_pkg::DIM_W'(1);
		end else if (dim_q > sqm_pkg::DIM_W'(MAX_DIM)) begin
			n_act = sqm_pkg::DIM_W'(MAX_DIM);
		end else begin
			n_act = dim_q;
		end
	end

	assign n_m1  = n_act - sqm_pkg::DIM_W'(1);
	assign total = sqm_pkg::CNT_W'(n_act) * sqm_pkg::CNT_W'(n_act);

	assign is_mul = (op_q == sqm_pkg::OP_MUL);
	assign is_sub = (op_q == sqm_pkg::OP_SUB);
	assign k_end  = ({1'b0, k_q} == n_m1);
	assign j_end  = ({1'b0, j_q} == n_m1);
	assign i_end  = ({1'b0, i_q} == n_m1);

	assign s_tready = (state_q == ST_LOAD);
	assign accept   = s_tvalid && s_tready;
	assign stall    = out_valid_q && !m_tready;
	assign issue    = (state_q == ST_RUN) && !stall;
	assign wr_addr  = load_q[AW-1:0];

	always_comb begin
		tag0.first  = !is_mul || (k_q == '0);
		tag0.lastk  = !is_mul || k_end;
		tag0.row    = i_q;
		tag0.col    = j_q;
		tag0.lastel = i_end && j_end;
		if (is_mul) begin
			addr_a = rowbase_q + AW'(k_q);
			addr_b = kbase_q + AW'(j_q);
		end else begin
			addr_a = rowbase_q + AW'(j_q);
			addr_b = rowbase_q + AW'(j_q);
		end
	end

	sqm_ram #(
		.WIDTH(DW),
		.DEPTH(DEPTH)
	) u_left_store (
		.clk    (clk),
		.wr_en  (accept),
		.wr_addr(wr_addr),
		.wr_data(s_tdata[31:0]),
		.rd_en  (!stall),
		.rd_addr(addr_a),
		.rd_data(a_rd)
	);

	sqm_ram #(
		.WIDTH(DW),
		.DEPTH(DEPTH)
	) u_right_store (
		.clk    (clk),
		.wr_en  (accept),
		.wr_addr(wr_addr),
		.wr_data(s_tdata[63:32]),
		.rd_en  (!stall),
		.rd_addr(addr_b),
		.rd_data(b_rd)
	);

	assign prod_lo = a_rd * b_rd;

	always_comb begin
		if (is_mul) begin
			term_d = prod_lo;
		end else if (is_sub) begin
			term_d = a_rd - b_rd;
		end else begin
			term_d = a_rd + b_rd;
		end
	end

	assign sum = tag_s2.first ? term_s2 : acc_q + term_s2;

	// Sequencer, load counter, configuration and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			op_q        <= sqm_pkg::OP_ADD;
			dim_q       <= sqm_pkg::DIM_W'(MAX_DIM);
			load_q      <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			rowbase_q   <= '0;
			kbase_q     <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				if (wr_index == sqm_pkg::REG_OPERATION) begin
					op_q <= wr_data[1:0];
				end else begin
					dim_q  <= wr_data;
					load_q <= '0;
				end
			end else if (accept) begin
				if (load_q == total - sqm_pkg::CNT_W'(1)) begin
					load_q    <= '0;
					state_q   <= ST_RUN;
					i_q       <= '0;
					j_q       <= '0;
					k_q       <= '0;
					rowbase_q <= '0;
					kbase_q   <= '0;
				end else begin
					load_q <= load_q + sqm_pkg::CNT_W'(1);
				end
			end

			if (issue) begin
				if (tag0.lastk) begin
					k_q     <= '0;
					kbase_q <= '0;
					if (j_end) begin
						j_q <= '0;
						if (i_end) begin
							state_q <= ST_LOAD;
						end else begin
							i_q       <= i_q + IW'(1);
							rowbase_q <= rowbase_q + AW'(n_act);
						end
					end else begin
						j_q <= j_q + IW'(1);
					end
				end else begin
					k_q     <= k_q + IW'(1);
					kbase_q <= kbase_q + AW'(n_act);
				end
			end

			// advance the pipeline unless the output register is blocked
			if (!stall) begin
				v_s1        <= (state_q == ST_RUN);
				v_s2        <= v_s1;
				out_valid_q <= v_s2 && tag_s2.lastk;
			end
		end
	end

	// Datapath payload
	always_ff @(posedge clk) begin
		if (!stall) begin
			tag_s1  <= tag0;
			tag_s2  <= tag_s1;
			term_s2 <= term_d;
			if (v_s2) begin
				acc_q <= sum;
				if (tag_s2.lastk) begin
					value_q <= sum;
					row_q   <= tag_s2.row;
					col_q   <= tag_s2.col;
					last_q  <= tag_s2.lastel;
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, col_q, row_q, value_q};
	assign m_tlast  = last_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 16;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int ITEM_TARGET = 380;

	typedef struct packed {
		logic [31:0] value;
		logic [2:0]  row;
		logic [2:0]  col;
		logic        last;
	} result_elem_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;   // a_elem[31:0], b_elem[63:32]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // value[31:0], row[34:32], col[37:35], zero pad
	logic        m_tlast;
	logic        wr_en = 1'b0;
	logic        wr_index = 1'b0;
	logic [3:0]  wr_data = '0;

	square_matrix_add_sub_mul_unit #(.MAX_DIM(8)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Matrix shadow state
	logic [31:0] left_mem [64];
	logic [31:0] right_mem [64];
	logic [6:0]  load_cnt = '0;
	logic [1:0]  cur_op = sqm_pkg::OP_ADD;
	logic [3:0]  cur_dim = 4'd8;

	result_elem_t expected_elems[$];
	logic [63:0]  pair_q[$];

	int  fail_count = 0;
	int  cycle_cnt = 0;
	int  items_queued = 0;
	int  send_gap = 0;
	int  recv_wait = 0;
	int  long_hold = 0;
	bit  no_gaps = 0;
	bit  start_long_hold = 0;
	int  tb_dim = 8;

	function automatic int active_n();
		if (cur_dim < 1)
			return 1;
		if (cur_dim > 8)
			return 8;
		return cur_dim;
	endfunction

	task automatic load_pair(input logic [63:0] pair);
		int n;
		int i;
		int j;
		int k;
		logic [31:0] acc;
		logic [31:0] prod;
		result_elem_t r;
		n = active_n();
		left_mem[load_cnt[5:0]] = pair[31:0];
		right_mem[load_cnt[5:0]] = pair[63:32];
		load_cnt = load_cnt + 7'd1;
		if (load_cnt >= n * n) begin
			load_cnt = '0;
			for (i = 0; i < n; i++) begin
				for (j = 0; j < n; j++) begin
					case (cur_op)
						sqm_pkg::OP_SUB: acc = left_mem[6'(i*n+j)] - right_mem[6'(i*n+j)];
						sqm_pkg::OP_MUL: begin
							acc = '0;
							for (k = 0; k < n; k++) begin
								prod = left_mem[6'(i*n+k)] * right_mem[6'(k*n+j)];
								acc = acc + prod;
							end
						end
						default: acc = left_mem[6'(i*n+j)] + right_mem[6'(i*n+j)];
					endcase
					r.value = acc;
					r.row = i[2:0];
					r.col = j[2:0];
					r.last = (i == n - 1) && (j == n - 1);
					expected_elems.push_back(r);
				end
			end
		end
	endtask

	// Shadow config writes and accepted items, check results
	always @(posedge clk) begin
		result_elem_t exp_r;
		if (arst_n) begin
			if (wr_en) begin
				if (wr_index == sqm_pkg::REG_OPERATION) begin
					cur_op = wr_data[1:0];
				end else begin
					cur_dim = wr_data;
					load_cnt = '0;
				end
			end
			if (s_tvalid && s_tready)
				load_pair(s_tdata);
			if (m_tvalid && m_tready) begin
				if (expected_elems.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: value %h row %0d col %0d last %b",
							m_tdata[31:0], m_tdata[34:32], m_tdata[37:35], m_tlast);
				end else begin
					exp_r = expected_elems.pop_front();
					if (m_tdata[31:0] !== exp_r.value || m_tdata[34:32] !== exp_r.row ||
							m_tdata[37:35] !== exp_r.col || m_tlast !== exp_r.last) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: exp value %h row %0d col %0d last %b, ",
								"got value %h row %0d col %0d last %b"},
								exp_r.value, exp_r.row, exp_r.col, exp_r.last,
								m_tdata[31:0], m_tdata[34:32], m_tdata[37:35], m_tlast);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Item driver: hold while stalled, otherwise gap or offer the next pair
	always @(posedge clk) begin
		if (arst_n && !(s_tvalid && !s_tready)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pair_q.size() > 0) begin
				s_tdata <= pair_q.pop_front();
				s_tvalid <= 1'b1;
				send_gap = no_gaps ? 0 : $urandom_range(0, 5);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver with random stalls and one long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (start_long_hold) begin
				start_long_hold = 0;
				long_hold = LONG_HOLD_CYCLES;
			end
			if (long_hold > 0) begin
				long_hold--;
				m_tready <= 1'b0;
			end else if (m_tvalid && m_tready) begin
				recv_wait = no_gaps ? 0 : $urandom_range(0, 5);
				m_tready <= (recv_wait == 0);
			end else if (recv_wait > 0) begin
				recv_wait--;
				m_tready <= (recv_wait == 0);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic logic [31:0] rand_elem();
		case ($urandom_range(0, 7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'hffff_ffff;
			3: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	task automatic push_pair(input logic [31:0] a, input logic [31:0] b);
		pair_q.push_back({b, a});
		items_queued++;
	endtask

	task automatic push_random(input int count);
		int c;
		for (c = 0; c < count; c++)
			push_pair(rand_elem(), rand_elem());
	endtask

	// Wait until the block has drained, then let the pipeline go quiet
	task automatic settle();
		do
			@(posedge clk);
		while (pair_q.size() != 0 || s_tvalid || expected_elems.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [3:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == sqm_pkg::REG_DIMENSION)
			tb_dim = (val < 1) ? 1 : (val > 8) ? 8 : val;
	endtask

	initial begin
		int n;
		int r;
		int kind;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: one-element matrices at the extremes of every operation
		write_reg(sqm_pkg::REG_DIMENSION, 4'd1);
		write_reg(sqm_pkg::REG_OPERATION, 4'(sqm_pkg::OP_ADD));
		push_pair(32'h7fff_ffff, 32'h0000_0001);
		push_pair(32'h8000_0000, 32'h8000_0000);
		settle();
		write_reg(sqm_pkg::REG_OPERATION, 4'(sqm_pkg::OP_SUB));
		push_pair(32'h8000_0000, 32'h0000_0001);
		push_pair(32'h0000_0000, 32'hffff_ffff);
		settle();
		write_reg(sqm_pkg::REG_OPERATION, 4'(sqm_pkg::OP_MUL));
		push_pair(32'hffff_ffff, 32'hffff_ffff);
		settle();
		// code three falls back to add
		write_reg(sqm_pkg::REG_OPERATION, 4'b1111);
		push_pair(32'h7fff_ffff, 32'h7fff_ffff);
		settle();
		// dimension zero acts as one
		write_reg(sqm_pkg::REG_DIMENSION, 4'd0);
		write_reg(sqm_pkg::REG_OPERATION, 4'(sqm_pkg::OP_MUL));
		push_pair(32'h8000_0000, 32'hffff_ffff);
		settle();
		write_reg(sqm_pkg::REG_DIMENSION, 4'd2);
		push_random(4);
		settle();
		// abandon a partial load by rewriting the dimension
		push_random(3);
		settle();
		write_reg(sqm_pkg::REG_DIMENSION, 4'd2);
		push_random(4);
		settle();
		// operation change mid-load applies to the completing item
		write_reg(sqm_pkg::REG_OPERATION, 4'(sqm_pkg::OP_ADD));
		push_random(2);
		settle();
		write_reg(sqm_pkg::REG_OPERATION, 4'(sqm_pkg::OP_MUL));
		push_random(2);
		settle();

		// Largest size: dimension above the maximum saturates
		write_reg(sqm_pkg::REG_DIMENSION, 4'd15);
		push_random(64);
		settle();
		write_reg(sqm_pkg::REG_DIMENSION, 4'd8);
		write_reg(sqm_pkg::REG_OPERATION, 4'(sqm_pkg::OP_SUB));
		push_random(64);
		settle();

		// Long receiver hold-off while three matrices are offered back to back
		no_gaps = 1;
		write_reg(sqm_pkg::REG_DIMENSION, 4'd4);
		write_reg(sqm_pkg::REG_OPERATION, 4'(sqm_pkg::OP_MUL));
		start_long_hold = 1;
		push_random(48);
		settle();
		no_gaps = 0;

		while (items_queued < ITEM_TARGET) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			write_reg(sqm_pkg::REG_OPERATION, 4'($urandom_range(0, 15)));
			if ($urandom_range(0, 1) == 0) begin
				r = $urandom_range(0, 19);
				if (r == 0)
					write_reg(sqm_pkg::REG_DIMENSION, 4'd0);
				else if (r == 1)
					write_reg(sqm_pkg::REG_DIMENSION, 4'($urandom_range(9, 15)));
				else if (r == 2)
					write_reg(sqm_pkg::REG_DIMENSION, 4'd8);
				else if (r <= 4)
					write_reg(sqm_pkg::REG_DIMENSION, 4'($urandom_range(5, 7)));
				else
					write_reg(sqm_pkg::REG_DIMENSION, 4'($urandom_range(1, 4)));
			end
			n = tb_dim;
			kind = $urandom_range(0, 9);
			if (kind == 0 && n > 1) begin
				// broken sequence: stop short, the next phase may restart it
				push_random($urandom_range(1, n * n - 1));
			end else if (n <= 4) begin
				push_random(n * n * $urandom_range(1, 2));
			end else begin
				push_random(n * n);
			end
			settle();
		end

		settle();
		repeat (40) @(posedge clk);
		if (expected_elems.size() != 0)
			fail_count += expected_elems.size();
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
